// ----- rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket deframer and unmasker.
// No dependencies; compiled first.
package wsd_pkg;

    localparam int LEN_W     = 63;
    localparam int ACC_W     = 64;
    localparam int KEY_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 4;

    localparam logic [6:0]         LEN7_EXT16  = 7'd126;
    localparam logic [6:0]         LEN7_EXT64  = 7'd127;
    localparam logic [COUNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [COUNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [COUNT_W-1:0] KEY_BYTES   = 4'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              fin_flag;
        logic [2:0]        reserved_bits;
        logic [3:0]        frame_opcode;
        logic              masked;
        logic [LEN_W-1:0]  payload_length;
        logic              length_error;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_frame;
    } wsd_result_t;

endpackage

// ----- rtl/wsd_if.sv -----
// Channel interfaces: raw stream bytes in, parsed results out, register writes.
// Depends on wsd_pkg for widths.
interface wsd_byte_if;
    import wsd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_result_if;
    import wsd_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic              fin_flag;
    logic [2:0]        reserved_bits;
    logic [3:0]        frame_opcode;
    logic              masked;
    logic [LEN_W-1:0]  payload_length;
    logic              length_error;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_frame;
    modport source (output valid, output kind, output fin_flag, output reserved_bits,
                    output frame_opcode, output masked, output payload_length,
                    output length_error, output payload_byte, output last_of_frame,
                    input ready);
    modport sink   (input valid, input kind, input fin_flag, input reserved_bits,
                    input frame_opcode, input masked, input payload_length,
                    input length_error, input payload_byte, input last_of_frame,
                    output ready);
endinterface

interface wsd_cfg_if;
    logic valid;
    logic ready;
    logic unmask_enable;
    modport source (output valid, output unmask_enable, input ready);
    modport sink   (input valid, input unmask_enable, output ready);
endinterface

// ----- rtl/websocket_deframe_unmask.sv -----
// Top level of the WebSocket deframer and unmasker.
// Depends on wsd_pkg and the channel interfaces in wsd_if.sv.
//
// Takes one stream byte per beat and parses RFC 6455 frame headers (flags and
// opcode, mask bit, 7/16/64-bit big-endian length, masking key), emitting one
// header result when the header is complete and then one result per payload
// byte, XORed with the key when unmask_enable is set and the frame is masked.
// The last result of each frame carries last_of_frame; a zero-length frame
// ends at its header. A set MSB of a 64-bit length raises length_error and is
// cleared. Each byte is handled by the parser register update, so a byte is
// taken every cycle while the skid stage is empty; results pass through an
// output register with a one-entry skid stage, so input stalls only when both are full.
// unmask_enable resets to 1 and is written through the setup channel.
module websocket_deframe_unmask
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    wsd_byte_if.sink          stream,
    wsd_result_if.source      result,
    wsd_cfg_if.sink           setup
);

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_EXT16  = 3'd2,
        PH_EXT64  = 3'd3,
        PH_KEY    = 3'd4,
        PH_DATA   = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         flags_reg, flags_next;
    logic               mask_bit_reg, mask_bit_next;
    logic [ACC_W-1:0]   len_reg, len_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [1:0]         key_idx_reg, key_idx_next;
    logic               unmask_reg;

    logic               out_valid_reg, skid_valid_reg;
    wsd_result_t        out_reg, skid_reg;

    logic               take;
    logic               produce;
    logic               len_done;
    logic               hdr_done;
    logic               last;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  key_byte;
    logic               kind;
    wsd_result_t        res;
    logic               out_move;

    assign stream.ready = !skid_valid_reg;
    assign take         = stream.valid && stream.ready;
    assign setup.ready  = 1'b1;

    assign key_byte = key_reg[{~key_idx_reg, 3'b000} +: BYTE_W];

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        flags_next   = flags_reg;
        mask_bit_next = mask_bit_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        rem_next     = rem_reg;
        key_idx_next = key_idx_reg;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        produce      = 1'b0;
        last         = 1'b0;
        kind         = KIND_HEADER;
        data_byte    = '0;
        if (take)
        begin
            unique case (phase_reg)
                PH_SECOND:
                begin
                    mask_bit_next = stream.stream_byte[7];
                    key_next      = '0;
                    len_next      = '0;
                    count_next    = '0;
                    if (stream.stream_byte[6:0] == LEN7_EXT16)
                    begin
                        phase_next = PH_EXT16;
                    end
                    else if (stream.stream_byte[6:0] == LEN7_EXT64)
                    begin
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        len_next = {{(ACC_W-7){1'b0}}, stream.stream_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_next   = {len_reg[ACC_W-BYTE_W-1:0], stream.stream_byte};
                    count_next = count_reg + 1'b1;
                    if (count_next >= ((phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                    begin
                        len_done = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next   = {key_reg[KEY_W-BYTE_W-1:0], stream.stream_byte};
                    count_next = count_reg + 1'b1;
                    if (count_next >= KEY_BYTES)
                    begin
                        hdr_done = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    data_byte    = (unmask_reg && mask_bit_reg) ?
                                   (stream.stream_byte ^ key_byte) : stream.stream_byte;
                    key_idx_next = key_idx_reg + 1'b1;
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - 1'b1;
                    end
                    last    = (rem_next == '0);
                    produce = 1'b1;
                    kind    = KIND_PAYLOAD;
                    if (last)
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                default:
                begin
                    flags_next = stream.stream_byte;
                    phase_next = PH_SECOND;
                end
            endcase

            if (len_done)
            begin
                count_next = '0;
                if (mask_bit_next)
                begin
                    phase_next = PH_KEY;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done)
            begin
                rem_next     = len_next[LEN_W-1:0];
                key_idx_next = '0;
                count_next   = '0;
                last         = (rem_next == '0);
                phase_next   = last ? PH_FIRST : PH_DATA;
                produce      = 1'b1;
            end
        end

        res.kind           = kind;
        res.fin_flag       = flags_next[7];
        res.reserved_bits  = flags_next[6:4];
        res.frame_opcode   = flags_next[3:0];
        res.masked         = mask_bit_next;
        res.payload_length = len_next[LEN_W-1:0];
        res.length_error   = len_next[ACC_W-1];
        res.payload_byte   = data_byte;
        res.last_of_frame  = last;
    end

    assign out_move = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            count_reg      <= '0;
            flags_reg      <= '0;
            mask_bit_reg   <= 1'b0;
            len_reg        <= '0;
            key_reg        <= '0;
            rem_reg        <= '0;
            key_idx_reg    <= '0;
            unmask_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            flags_reg    <= flags_next;
            mask_bit_reg <= mask_bit_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            rem_reg      <= rem_next;
            key_idx_reg  <= key_idx_next;
            if (setup.valid && setup.ready)
            begin
                unmask_reg <= setup.unmask_enable;
            end
            if (out_move)
            begin
                out_valid_reg  <= skid_valid_reg || produce;
                skid_valid_reg <= 1'b0;
                out_reg        <= skid_valid_reg ? skid_reg : res;
            end
            else if (produce)
            begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= res;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_reg.kind;
    assign result.fin_flag       = out_reg.fin_flag;
    assign result.reserved_bits  = out_reg.reserved_bits;
    assign result.frame_opcode   = out_reg.frame_opcode;
    assign result.masked         = out_reg.masked;
    assign result.payload_length = out_reg.payload_length;
    assign result.length_error   = out_reg.length_error;
    assign result.payload_byte   = out_reg.payload_byte;
    assign result.last_of_frame  = out_reg.last_of_frame;

endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for websocket_deframe_unmask: drives stream and setup beats,
// predicts header and payload results in step, checks every result beat field by field.
// Depends on wsd_pkg and the channel interfaces in wsd_if.sv.
`timescale 1ns / 1ps

module testbench;
    import wsd_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BEATS   = 450;

    typedef enum logic [2:0] {
        ST_FIRST, ST_SECOND, ST_EXT16, ST_EXT64, ST_KEY, ST_DATA
    } parse_state_t;

    typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_t;

    logic clk = 1'b0;
    logic rst_n;

    wsd_byte_if   stream_if ();
    wsd_result_if result_if ();
    wsd_cfg_if    setup_if ();

    websocket_deframe_unmask dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if),
        .setup  (setup_if)
    );

    always #6 clk = ~clk;

    parse_state_t      parse_st   = ST_FIRST;
    logic [3:0]        hdr_count  = '0;
    logic [7:0]        flags_op   = '0;
    logic              mask_bit   = 1'b0;
    logic [ACC_W-1:0]  len_acc    = '0;
    logic [KEY_W-1:0]  key_reg    = '0;
    logic [LEN_W-1:0]  left_count = '0;
    logic [1:0]        key_pos    = '0;
    logic              unmask_on  = 1'b1;

    wsd_result_t expected_results[$];
    wsd_result_t want;

    int cycle_count     = 0;
    int mismatches      = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int headers_seen    = 0;
    int len_errors_seen = 0;
    int idle_pct        = 0;
    int stall_pct       = 0;
    int hold_left       = 0;

    function automatic void push_expected(input logic kind, input logic [7:0] data,
                                          input logic tail);
        wsd_result_t r;
        r.kind           = kind;
        r.fin_flag       = flags_op[7];
        r.reserved_bits  = flags_op[6:4];
        r.frame_opcode   = flags_op[3:0];
        r.masked         = mask_bit;
        r.payload_length = len_acc[LEN_W-1:0];
        r.length_error   = len_acc[ACC_W-1];
        r.payload_byte   = data;
        r.last_of_frame  = tail;
        expected_results.push_back(r);
    endfunction

    function automatic void header_done();
        left_count = len_acc[LEN_W-1:0];
        key_pos    = '0;
        hdr_count  = '0;
        parse_st   = (left_count == 0) ? ST_FIRST : ST_DATA;
        push_expected(KIND_HEADER, 8'h00, left_count == 0);
    endfunction

    function automatic void length_done();
        hdr_count = '0;
        if (mask_bit)
            parse_st = ST_KEY;
        else
            header_done();
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] d;
        logic       tail;
        d = b;
        unique case (parse_st)
            ST_SECOND:
            begin
                mask_bit  = b[7];
                key_reg   = '0;
                len_acc   = '0;
                hdr_count = '0;
                if (b[6:0] == LEN7_EXT16)
                    parse_st = ST_EXT16;
                else if (b[6:0] == LEN7_EXT64)
                    parse_st = ST_EXT64;
                else
                begin
                    len_acc = ACC_W'(b[6:0]);
                    length_done();
                end
            end
            ST_EXT16, ST_EXT64:
            begin
                len_acc   = {len_acc[ACC_W-9:0], b};
                hdr_count = hdr_count + 1'b1;
                if (hdr_count >= ((parse_st == ST_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                    length_done();
            end
            ST_KEY:
            begin
                key_reg   = {key_reg[KEY_W-9:0], b};
                hdr_count = hdr_count + 1'b1;
                if (hdr_count >= KEY_BYTES)
                    header_done();
            end
            ST_DATA:
            begin
                if (unmask_on && mask_bit)
                    d = b ^ key_reg[31 - 8 * int'(key_pos) -: 8];
                key_pos = key_pos + 1'b1;
                if (left_count != 0)
                    left_count = left_count - 1'b1;
                tail = (left_count == 0);
                if (tail)
                    parse_st = ST_FIRST;
                push_expected(KIND_PAYLOAD, d, tail);
            end
            default:
            begin
                flags_op = b;
                parse_st = ST_SECOND;
            end
        endcase
    endfunction

    task automatic report(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        if (got !== exp_val)
            report($sformatf("%s got %0h, want %0h", name, got, exp_val));
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (setup_if.valid && setup_if.ready)
                unmask_on = setup_if.unmask_enable;
            if (stream_if.valid && stream_if.ready)
                deframe_byte(stream_if.stream_byte);
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("kind", 64'(result_if.kind), 64'(want.kind));
                    compare_field("fin_flag", 64'(result_if.fin_flag), 64'(want.fin_flag));
                    compare_field("reserved_bits", 64'(result_if.reserved_bits),
                                  64'(want.reserved_bits));
                    compare_field("frame_opcode", 64'(result_if.frame_opcode),
                                  64'(want.frame_opcode));
                    compare_field("masked", 64'(result_if.masked), 64'(want.masked));
                    compare_field("payload_length", 64'(result_if.payload_length),
                                  64'(want.payload_length));
                    compare_field("length_error", 64'(result_if.length_error),
                                  64'(want.length_error));
                    compare_field("payload_byte", 64'(result_if.payload_byte),
                                  64'(want.payload_byte));
                    compare_field("last_of_frame", 64'(result_if.last_of_frame),
                                  64'(want.last_of_frame));
                    results_checked++;
                    if (want.kind == KIND_HEADER)
                    begin
                        headers_seen++;
                        if (want.length_error)
                            len_errors_seen++;
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        do
            @(posedge clk);
        while (!stream_if.ready);
        beats_sent++;
    endtask

    task automatic send_frame(input logic [7:0] flags, input logic masked_frame,
                              input len_form_t form, input logic [63:0] raw_len,
                              input logic [31:0] key, input int n_payload);
        logic [6:0] code;
        code = (form == LEN_16) ? LEN7_EXT16 : (form == LEN_64) ? LEN7_EXT64 : raw_len[6:0];
        send_byte(flags);
        send_byte({masked_frame, code});
        if (form == LEN_16)
        begin
            send_byte(raw_len[15:8]);
            send_byte(raw_len[7:0]);
        end
        else if (form == LEN_64)
            for (int i = 7; i >= 0; i--)
                send_byte(raw_len[8 * i +: 8]);
        if (masked_frame)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        for (int i = 0; i < n_payload; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic random_frame();
        logic [63:0] raw;
        len_form_t   form;
        int          pick;
        pick = $urandom_range(99);
        raw  = '0;
        if (pick < 60)
        begin
            form = LEN_SHORT;
            raw  = 64'($urandom_range(20));
        end
        else if (pick < 70)
        begin
            form = LEN_SHORT;
            raw  = 64'($urandom_range(125));
        end
        else if (pick < 85)
        begin
            form = LEN_16;
            raw  = 64'($urandom_range(40));
        end
        else
        begin
            form    = LEN_64;
            raw     = 64'($urandom_range(24));
            raw[63] = 1'($urandom_range(1));
        end
        send_frame(8'($urandom_range(255)), $urandom_range(3) != 0, form, raw, $urandom,
                   int'(raw[LEN_W-1:0]));
    endtask

    task automatic settle();
        stream_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_unmask(input logic on);
        settle();
        setup_if.unmask_enable <= on;
        setup_if.valid         <= 1'b1;
        do
            @(posedge clk);
        while (!setup_if.ready);
        setup_if.valid <= 1'b0;
    endtask

    task automatic run_random(input int idle, input int stall, input int beats);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = beats_sent;
        while (beats_sent - start < beats)
            random_frame();
        settle();
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_frame(8'h81, 1'b1, LEN_SHORT, 64'd3, 32'hFF00_A55A, 3);
        send_frame(8'h89, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
        send_frame(8'hFF, 1'b0, LEN_16, 64'd2, 32'h0, 2);
        send_frame(8'h00, 1'b0, LEN_64, 64'h8000_0000_0000_0001, 32'h0, 1);
        settle();
    endtask

    task automatic test_unmask_off();
        set_unmask(1'b0);
        send_frame(8'h82, 1'b1, LEN_SHORT, 64'd12, 32'hFFFF_FFFF, 12);
        send_frame(8'h02, 1'b1, LEN_16, 64'd9, $urandom, 9);
        send_frame(8'h01, 1'b0, LEN_SHORT, 64'd5, 32'h0, 5);
        set_unmask(1'b1);
    endtask

    task automatic test_random_phases();
        run_random(0, 0, PHASE_BEATS);
        set_unmask(1'b0);
        run_random(88, 0, PHASE_BEATS);
        set_unmask(1'b1);
        run_random(0, 88, PHASE_BEATS);
        set_unmask(1'($urandom_range(1)));
        run_random(11, 11, PHASE_BEATS);
        set_unmask(1'b1);
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 500;
        send_frame(8'h82, 1'b1, LEN_SHORT, 64'd48, $urandom, 48);
        settle();
    endtask

    // leave this frame open: its length can never be carried in full
    task automatic test_length_extremes();
        idle_pct  = 11;
        stall_pct = 11;
        send_frame(8'h8F, 1'b1, LEN_64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 6);
        settle();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        stream_if.valid        = 1'b0;
        stream_if.stream_byte  = '0;
        result_if.ready        = 1'b0;
        setup_if.valid         = 1'b0;
        setup_if.unmask_enable = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_unmask_off();
        test_random_phases();
        test_backpressure();
        test_length_extremes();

        if (expected_results.size() != 0)
            report($sformatf("%0d results never arrived", expected_results.size()));
        $display("Sent %0d stream beats; checked %0d result beats, %0d of them headers.",
                 beats_sent, results_checked, headers_seen);
        $display("Both unmask settings, %0d oversized lengths, long receiver hold-off.",
                 len_errors_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
